// File: hdl/flbh_pkg.sv
package flbh_pkg;

    localparam int LaneW = 32;

    typedef logic [LaneW-1:0] word_t;

    typedef struct packed {
        logic load_byte;
        logic load_pad;
        logic start_round;
        logic reload;
    } cmd_t;

    typedef struct packed {
        logic [5:0] pos;
        logic       round_done;
        logic       sub_done;
    } stat_t;

    localparam word_t LaneStart [4] = '{
        32'd1700003491, 32'd2117061241, 32'd3333300367, 32'd4127628919
    };

    function automatic word_t prime(input logic [3:0] i);
        word_t r;
        case (i)
            4'd0:  r = 32'd9257;
            4'd1:  r = 32'd1855519;
            4'd2:  r = 32'd2958503;
            4'd3:  r = 32'd1001750039;
            4'd4:  r = 32'd1000000007;
            4'd5:  r = 32'd1000003519;
            4'd6:  r = 32'd2000004359;
            4'd7:  r = 32'd2010751433;
            4'd8:  r = 32'd2010759071;
            4'd9:  r = 32'd3000253777;
            4'd10: r = 32'd3000261653;
            4'd11: r = 32'd3501650023;
            4'd12: r = 32'd3802051789;
            4'd13: r = 32'd4002954971;
            4'd14: r = 32'd4102703677;
            default: r = 32'd4202950013;
        endcase
        return r;
    endfunction

    function automatic word_t pad_word(input logic [3:0] i);
        word_t r;
        case (i)
            4'd0:  r = 32'd2718281828;
            4'd1:  r = 32'd459045235;
            4'd2:  r = 32'd3602874713;
            4'd3:  r = 32'd526624977;
            4'd4:  r = 32'd572470936;
            4'd5:  r = 32'd999595749;
            4'd6:  r = 32'd669676277;
            4'd7:  r = 32'd2407663035;
            4'd8:  r = 32'd3547594571;
            4'd9:  r = 32'd3821785251;
            4'd10: r = 32'd664274274;
            4'd11: r = 32'd6639193;
            4'd12: r = 32'd200305992;
            4'd13: r = 32'd181741;
            4'd14: r = 32'd359662904;
            default: r = 32'd357290033;
        endcase
        return r;
    endfunction

    function automatic word_t sx8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    function automatic word_t byte_mix(input logic [7:0] t, input logic [7:0] n);
        logic [7:0] r;
        r = {t[5:0], 2'b00} ^ {{3{t[7]}}, t[7:3]} ^ n;
        return sx8(r);
    endfunction

endpackage

// File: hdl/flbh_datapath.sv
module flbh_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  flbh_pkg::cmd_t       cmd,
    input  logic [7:0]           data_byte,
    output flbh_pkg::stat_t      stat,
    output logic [63:0]          hash_value
);

    logic [7:0]       store_reg [16];
    flbh_pkg::word_t  lane_reg [4];
    logic [5:0]       pos_reg;
    logic [1:0]       rnd_reg;
    logic [1:0]       phase_reg;
    flbh_pkg::word_t  prod_a_reg, prod_b_reg, m2_reg;
    flbh_pkg::word_t  x3, m0, x0, m1, x1, m2, mix_sum, prod_a, prod_b;
    flbh_pkg::word_t  pr2, pr6, pword;
    logic [7:0]       pb;
    logic [7:0]       pbyte;

    always_comb begin
        x3 = flbh_pkg::sx8(store_reg[0]) ^ flbh_pkg::sx8(store_reg[2])
           ^ flbh_pkg::sx8(store_reg[4]) ^ flbh_pkg::sx8(store_reg[6])
           ^ flbh_pkg::prime(store_reg[0][3:0]) ^ flbh_pkg::prime(store_reg[2][3:0])
           ^ flbh_pkg::prime(store_reg[4][3:0]) ^ flbh_pkg::prime(store_reg[6][3:0]);
        pr2 = flbh_pkg::prime(store_reg[2][3:0]);
        pr6 = flbh_pkg::prime(store_reg[6][3:0]);
        m0 = flbh_pkg::prime(store_reg[1][3:0]) ^ flbh_pkg::prime(store_reg[3][3:0])
           ^ flbh_pkg::prime(store_reg[5][3:0]) ^ flbh_pkg::prime(store_reg[7][3:0])
           ^ flbh_pkg::byte_mix(pr2[7:0], pr6[7:0]);
        x0 = flbh_pkg::sx8(store_reg[1] ^ store_reg[3] ^ store_reg[5] ^ store_reg[7]);
        mix_sum = flbh_pkg::byte_mix(store_reg[8], store_reg[10])
                + flbh_pkg::byte_mix(store_reg[14], store_reg[12]);
        m1 = flbh_pkg::prime(store_reg[8][3:0]) ^ flbh_pkg::prime(store_reg[10][3:0])
           ^ flbh_pkg::prime(store_reg[12][3:0]) ^ flbh_pkg::prime(store_reg[14][3:0])
           ^ flbh_pkg::prime(mix_sum[3:0]);
        x1 = flbh_pkg::sx8(store_reg[8] ^ store_reg[10] ^ store_reg[12] ^ store_reg[14]);
        m2 = flbh_pkg::sx8(store_reg[9] ^ store_reg[11] ^ store_reg[13] ^ store_reg[15])
           ^ flbh_pkg::prime(store_reg[9][3:0]) ^ flbh_pkg::prime(store_reg[11][3:0])
           ^ flbh_pkg::prime(store_reg[13][3:0]) ^ flbh_pkg::prime(store_reg[15][3:0])
           ^ flbh_pkg::prime(store_reg[14][3:0]);
        prod_a = x0 * m0;
        prod_b = x1 * m1;
        pword = flbh_pkg::pad_word(pos_reg[5:2]) >> {pos_reg[1:0], 3'b000};
        pbyte = pword[7:0];
        pb = cmd.load_pad ? pbyte : data_byte;
    end

    // phase 1 registers products, phase 2 writes rotated lanes
    always_ff @(posedge aclk) begin
        if (cmd.load_byte || cmd.load_pad) begin
            store_reg[pos_reg[3:0]] <= pb;
        end
        if (phase_reg == 2'd1) begin
            prod_a_reg <= prod_a;
            prod_b_reg <= prod_b;
            m2_reg     <= m2;
        end
        if (!aresetn || cmd.reload) begin
            for (int i = 0; i < 4; i++) lane_reg[i] <= flbh_pkg::LaneStart[i];
        end else if (phase_reg == 2'd2) begin
            // rotate right: new lane k+1 gets old-updated lane k
            lane_reg[1] <= lane_reg[0] - prod_a_reg;
            lane_reg[2] <= lane_reg[1] + prod_b_reg;
            lane_reg[3] <= lane_reg[2] ^ ({m2_reg[27:0], 4'b0} + m2_reg);
            lane_reg[0] <= lane_reg[3] ^ x3;
        end
        if (!aresetn || cmd.reload) begin
            pos_reg   <= '0;
            phase_reg <= '0;
            rnd_reg   <= '0;
        end else begin
            if (cmd.load_byte || cmd.load_pad) pos_reg <= pos_reg + 6'd1;
            if (cmd.start_round) phase_reg <= 2'd1;
            else if (phase_reg == 2'd1) phase_reg <= 2'd2;
            else if (phase_reg == 2'd2) begin
                phase_reg <= 2'd0;
                rnd_reg   <= rnd_reg + 2'd1;
            end
        end
    end

    assign stat.pos        = pos_reg;
    assign stat.round_done = (phase_reg == 2'd2);
    assign stat.sub_done   = (phase_reg == 2'd2) && (rnd_reg == 2'd3);
    assign hash_value = {lane_reg[0] ^ lane_reg[3], lane_reg[1] ^ lane_reg[2]};

endmodule

// File: hdl/flbh_ctrl.sv
module flbh_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  logic            in_last,
    input  logic            out_ready,
    input  flbh_pkg::stat_t stat,
    output flbh_pkg::cmd_t  cmd,
    output logic            in_ready,
    output logic            out_valid
);

    typedef enum logic [4:0] {
        IDLE  = 5'b00001,
        ROUND = 5'b00010,
        WAIT  = 5'b00100,
        PAD   = 5'b01000,
        OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;
    logic   wrap;

    assign wrap = (stat.pos[3:0] == 4'hf);

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        in_ready   = (state_reg == IDLE);
        out_valid  = (state_reg == OUT);
        case (state_reg)
            IDLE: begin
                if (in_fire) begin
                    cmd.load_byte = 1'b1;
                    last_next     = in_last;
                    if (wrap) state_next = ROUND;
                    else if (in_last) state_next = PAD;
                end
            end
            ROUND: begin
                cmd.start_round = 1'b1;
                state_next      = WAIT;
            end
            WAIT: begin
                if (stat.sub_done) begin
                    if (!last_reg) state_next = IDLE;
                    else if (stat.pos == 6'd0) state_next = OUT;
                    else state_next = PAD;
                end else if (stat.round_done) begin
                    state_next = ROUND;
                end
            end
            PAD: begin
                cmd.load_pad = 1'b1;
                if (wrap) state_next = ROUND;
            end
            OUT: begin
                if (out_ready) begin
                    cmd.reload = 1'b1;
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

endmodule

// File: hdl/four_lane_block_hash_top.sv
// Channel | Dir | tdata               | tuser/tlast
// s_      | in  | [7:0] data_byte     | tlast = last_byte
// m_      | out | [63:0] hash_value   | -
// A byte closing a 16-byte sub-block starts four rounds; each registers
// the two products, then rotates the lanes. A final byte pads the block
// one byte a cycle between sub-block rounds, hashes the rest and holds
// the result. Reset is synchronous; input is stalled while a result waits.
module four_lane_block_hash_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [63:0] hash_value
);

    flbh_pkg::cmd_t  cmd;
    flbh_pkg::stat_t stat;

    flbh_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_fire(s_tvalid && s_tready), .in_last(s_tlast),
        .out_ready(m_tready), .stat(stat), .cmd(cmd),
        .in_ready(s_tready), .out_valid(m_tvalid)
    );

    flbh_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .data_byte(s_tdata), .stat(stat), .hash_value(m_tdata)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input open while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed");

endmodule
